/* rtl/core/gscs_pkg.sv */
// Shared types and constants of the golden-section coordinate search.
`default_nettype none

package gscs_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int VALUE_W    = 17;
   localparam int IDX_W      = 8;
   localparam int COUNT_W    = 9;
   localparam int FIT_W      = 32;
   localparam int MAX_COORDS = 256;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COORDS);
   localparam logic [VALUE_W-1:0] ONE_Q     = VALUE_W'(64'd1 << FRAC_BITS);
   // floor(0.6180339887 * 2^FRAC_BITS)
   localparam logic [FRAC_BITS-1:0] GOLD    = FRAC_BITS'(64'd2654435769 >> (32 - FRAC_BITS));
   // first inner points of [0, 1.0]
   localparam logic [VALUE_W-1:0] INIT_HIGH = VALUE_W'(GOLD);
   localparam logic [VALUE_W-1:0] INIT_LOW  =
      VALUE_W'((64'(GOLD) * 64'(GOLD)) >> FRAC_BITS);
   localparam logic [VALUE_W-1:0] TOL_RESET = VALUE_W'(66);

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_FITNESS = 1'b1;
   localparam logic KIND_PROBE   = 1'b0;
   localparam logic KIND_SETTLED = 1'b1;

   typedef enum logic [1:0] {
      PH_FIRST_LOW,
      PH_FIRST_HIGH,
      PH_NEW_LOW,
      PH_NEW_HIGH
   } phase_type;

   typedef struct packed {
      logic               kind;
      logic [IDX_W-1:0]   coord_index;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

   typedef struct packed {
      logic               busy;
      phase_type          phase;
      logic [IDX_W-1:0]   coord;
      logic [COUNT_W-1:0] total;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/gscs_engine.sv */
// Search state and single-pass update for one input item.
`default_nettype none

module gscs_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire logic                          item_func,
   input  wire logic [gscs_pkg::COUNT_W-1:0]  item_count,
   input  wire logic [gscs_pkg::FIT_W-1:0]    item_fitness,
   input  wire logic                          csr_wr_en,
   input  wire logic [gscs_pkg::VALUE_W-1:0]  csr_wr_data,
   output gscs_pkg::result_type               push_a,
   output gscs_pkg::result_type               push_b,
   output logic [1:0]                         push_count,
   output gscs_pkg::status_type               status
);
   import gscs_pkg::*;

   logic [VALUE_W-1:0]      tol_ff;
   logic                    busy_ff, busy_in;
   phase_type               phase_ff, phase_in;
   logic [IDX_W-1:0]        coord_ff, coord_in;
   logic [COUNT_W-1:0]      total_ff, total_in;
   logic [VALUE_W-1:0]      low_ff, low_in, high_ff, high_in;
   logic [VALUE_W-1:0]      ilow_ff, ilow_in, ihigh_ff, ihigh_in;
   logic signed [FIT_W-1:0] flow_ff, flow_in, fhigh_ff, fhigh_in;

   logic signed [FIT_W-1:0] fit;
   logic signed [FIT_W-1:0] flow_eff, fhigh_eff;
   logic                    do_start, do_first, do_adv;
   logic                    settle, drop_upper, final_coord;
   logic [VALUE_W-1:0]      width, tol_eff;
   logic [VALUE_W-1:0]      gp_a, gp_b, gp_diff, gp;
   logic [VALUE_W+FRAC_BITS-1:0] gp_prod;
   logic [IDX_W-1:0]        coord_next;

   assign fit = $signed(item_fitness);

   assign do_start = item_valid && (item_func == FUNC_START) && !busy_ff
                     && (item_count != '0);
   assign do_first = item_valid && (item_func == FUNC_FITNESS) && busy_ff
                     && (phase_ff == PH_FIRST_LOW);
   assign do_adv   = item_valid && (item_func == FUNC_FITNESS) && busy_ff
                     && (phase_ff != PH_FIRST_LOW);

   // the fresh score replaces whichever inner score the phase waits for
   always_comb begin
      flow_eff  = flow_ff;
      fhigh_eff = fhigh_ff;
      if (phase_ff == PH_NEW_LOW) begin
         flow_eff = fit;
      end else begin
         fhigh_eff = fit;
      end
   end

   assign width       = (high_ff > low_ff) ? (high_ff - low_ff) : '0;
   assign tol_eff     = (tol_ff == '0) ? VALUE_W'(1) : tol_ff;
   assign settle      = (width <= tol_eff);
   assign drop_upper  = (flow_eff > fhigh_eff);
   assign final_coord = ({1'b0, coord_ff} + COUNT_W'(1)) >= total_ff;
   assign coord_next  = coord_ff + IDX_W'(1);

   // one shared golden-point unit: settle on [ilow, ihigh], shrink upper on
   // [low, ilow], shrink lower on [ilow, high]
   always_comb begin
      if (settle) begin
         gp_a = ilow_ff;
         gp_b = ihigh_ff;
      end else if (drop_upper) begin
         gp_a = low_ff;
         gp_b = ilow_ff;
      end else begin
         gp_a = ilow_ff;
         gp_b = high_ff;
      end
   end

   assign gp_diff = (gp_b > gp_a) ? (gp_b - gp_a) : '0;
   assign gp_prod = (VALUE_W+FRAC_BITS)'(GOLD) * (VALUE_W+FRAC_BITS)'(gp_diff);
   assign gp      = gp_a + gp_prod[FRAC_BITS +: VALUE_W];

   // next state
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      coord_in = coord_ff;
      total_in = total_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      ilow_in  = ilow_ff;
      ihigh_in = ihigh_ff;
      flow_in  = flow_ff;
      fhigh_in = fhigh_ff;
      if (do_start) begin
         total_in = (item_count > MAX_COUNT) ? MAX_COUNT : item_count;
         coord_in = '0;
         busy_in  = 1'b1;
         low_in   = '0;
         high_in  = ONE_Q;
         ihigh_in = INIT_HIGH;
         ilow_in  = INIT_LOW;
         phase_in = PH_FIRST_LOW;
      end else if (do_first) begin
         flow_in  = fit;
         phase_in = PH_FIRST_HIGH;
      end else if (do_adv) begin
         flow_in  = flow_eff;
         fhigh_in = fhigh_eff;
         if (settle) begin
            if (final_coord) begin
               busy_in  = 1'b0;
               phase_in = PH_FIRST_LOW;
            end else begin
               coord_in = coord_next;
               low_in   = '0;
               high_in  = ONE_Q;
               ihigh_in = INIT_HIGH;
               ilow_in  = INIT_LOW;
               phase_in = PH_FIRST_LOW;
            end
         end else if (drop_upper) begin
            high_in  = ihigh_ff;
            ihigh_in = ilow_ff;
            fhigh_in = flow_eff;
            ilow_in  = gp;
            phase_in = PH_NEW_LOW;
         end else begin
            low_in   = ilow_ff;
            ilow_in  = ihigh_ff;
            flow_in  = fhigh_eff;
            ihigh_in = gp;
            phase_in = PH_NEW_HIGH;
         end
      end
   end

   // results
   always_comb begin
      push_count = 2'd0;
      push_a     = '{kind: KIND_PROBE, coord_index: coord_ff, value: gp, last: 1'b0};
      push_b     = '{kind: KIND_PROBE, coord_index: coord_next, value: INIT_LOW,
                     last: 1'b0};
      if (do_start) begin
         push_count = 2'd1;
         push_a     = '{kind: KIND_PROBE, coord_index: '0, value: INIT_LOW, last: 1'b0};
      end else if (do_first) begin
         push_count = 2'd1;
         push_a.value = ihigh_ff;
      end else if (do_adv) begin
         if (settle) begin
            push_a.kind = KIND_SETTLED;
            push_a.last = final_coord;
            push_count  = final_coord ? 2'd1 : 2'd2;
         end else begin
            push_count = 2'd1;
         end
      end
   end

   assign status = '{busy: busy_ff, phase: phase_ff, coord: coord_ff, total: total_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         busy_ff  <= 1'b0;
         phase_ff <= PH_FIRST_LOW;
         coord_ff <= '0;
         total_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         coord_ff <= coord_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      ilow_ff  <= ilow_in;
      ihigh_ff <= ihigh_in;
      flow_ff  <= flow_in;
      fhigh_ff <= fhigh_in;
   end

endmodule

`default_nettype wire

/* rtl/core/gscs_result_fifo.sv */
// Four-entry result queue taking up to two results per cycle.
`default_nettype none

module gscs_result_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire gscs_pkg::result_type push_a,
   input  wire gscs_pkg::result_type push_b,
   input  wire logic [1:0]    push_count,
   output logic               room_for_two,
   output logic               out_valid,
   input  wire logic          out_ready,
   output gscs_pkg::result_type out_item
);
   import gscs_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   result_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               pop;
   logic [PTR_W-1:0]   wr_ptr_b;

   assign out_valid    = (count_ff != '0);
   assign out_item     = mem_ff[rd_ptr_ff];
   assign pop          = out_valid && out_ready;
   assign room_for_two = (count_ff <= (PTR_W+1)'(DEPTH - 2));
   assign wr_ptr_b     = wr_ptr_ff + PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + (PTR_W+1)'(push_count) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_b] <= push_b;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/golden_section_coordinate_search.sv */
// Top level: input register, search engine and result queue.
`default_nettype none

// Coordinate-wise golden-section maximizer. Send a start transfer (tuser 0)
// with the coordinate count; the block answers with probe points (tuser 0)
// that an outside evaluator scores and returns as fitness transfers
// (tuser 1), one per probe. When a coordinate's interval is within the
// tolerance, a settled value (tuser 1) follows, tlast on the final one.
// Each input transfer is registered and handled by a single golden-point
// multiplier, so an item can be taken every cycle while the queue has room
// for two results; results drain through a four-entry queue at one per
// cycle while rsp_tready is high, and a response that settles a non-final
// coordinate yields two results (settled value, then the next coordinate's
// first probe). Results come through the input register, then the queue;
// transfers that do not fit the current phase are dropped without a result.
module golden_section_coordinate_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [8:0] coord_count, [40:9] fitness, [47:41] zero
   input  wire logic [47:0]                   req_tdata,
   // [0] func
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] coord_index, [24:8] value, [31:25] zero
   output logic [31:0]                        rsp_tdata,
   // [0] kind
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  wire logic                          csr_wr_en,
   input  wire logic [gscs_pkg::VALUE_W-1:0]  csr_wr_data
);
   import gscs_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic               in_func_ff;
   logic [COUNT_W-1:0] in_count_ff;
   logic [FIT_W-1:0]   in_fit_ff;
   logic               room_for_two;
   logic               in_fire;
   logic               req_xfer;
   result_type         push_a, push_b, out_item;
   logic [1:0]         push_count;
   status_type         status;

   assign in_fire    = in_valid_ff && room_for_two;
   assign req_tready = !in_valid_ff || room_for_two;
   assign req_xfer   = req_tvalid && req_tready;
   assign in_valid_in = req_xfer || (in_valid_ff && !in_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_func_ff  <= req_tuser;
         in_count_ff <= req_tdata[COUNT_W-1:0];
         in_fit_ff   <= req_tdata[COUNT_W +: FIT_W];
      end
   end

   gscs_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (in_fire),
      .item_func    (in_func_ff),
      .item_count   (in_count_ff),
      .item_fitness (in_fit_ff),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .push_a       (push_a),
      .push_b       (push_b),
      .push_count   (push_count),
      .status       (status)
   );

   gscs_result_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_a       (push_a),
      .push_b       (push_b),
      .push_count   (push_count),
      .room_for_two (room_for_two),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_item     (out_item)
   );

   assign rsp_tdata = {7'd0, out_item.value, out_item.coord_index};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

`ifndef SYNTH
   a_last_only_on_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_SETTLED)
      else $error("tlast on a probe result");

   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> status.phase == PH_FIRST_LOW)
      else $error("idle with a search phase pending");

   a_coord_in_range: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> ({1'b0, status.coord} < status.total))
      else $error("coordinate index beyond count");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !in_fire |-> push_count == 2'd0)
      else $error("result pushed without an item");
`endif

endmodule

`default_nettype wire
